>>> hw/rtl/go_to_goal_wheel_speed_assert.svh
// Assertion macros shared by the go-to-goal wheel speed checker
`ifndef GO_TO_GOAL_WHEEL_SPEED_ASSERT_SVH
`define GO_TO_GOAL_WHEEL_SPEED_ASSERT_SVH

// Clocked check, muted while reset is asserted
`define GGWS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds across reset
`define GGWS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/ggws_pkg.sv
// Package: widths, angle constants, register map and arctangent table
package ggws_pkg;

	localparam int XW = 28;
	localparam int ZW = 28;
	localparam int DW = 27;
	localparam int EW = 30;
	localparam int ADDR_W = 5;
	localparam int CORDIC_STAGES_DEF = 16;

	localparam logic signed [EW-1:0] ANG_HALF_PI = 30'sd26353589;
	localparam logic signed [EW-1:0] ANG_PI = 30'sd52707179;
	localparam logic signed [EW-1:0] ANG_TWO_PI = 30'sd105414357;
	localparam logic signed [17:0] INV_K_Q16 = 18'sd39797;
	localparam logic signed [XW-1:0] INV_K_Q24 = 28'sd10188014;

	localparam logic signed [15:0] RST_GOAL_X = 16'sd0;
	localparam logic signed [15:0] RST_GOAL_Y = 16'sd0;
	localparam logic [15:0] RST_GAIN_FORWARD = 16'd256;
	localparam logic [15:0] RST_GAIN_TURN = 16'd256;
	localparam logic [9:0] RST_HALF_AXLE = 10'd26;
	localparam logic [15:0] RST_WHEEL_SCALE = 16'd12490;
	localparam logic [14:0] RST_SPEED_LIMIT = 15'd1000;

	typedef enum logic [2:0] {
		REG_GOAL_X,
		REG_GOAL_Y,
		REG_GAIN_FORWARD,
		REG_GAIN_TURN,
		REG_HALF_AXLE,
		REG_WHEEL_SCALE,
		REG_SPEED_LIMIT
	} reg_idx_t;

	// atan(2^-i) in Q.24 radians
	function automatic logic signed [ZW-1:0] atan_q24(input int unsigned i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 28'sd13176795;
			1: r = 28'sd7778716;
			2: r = 28'sd4110060;
			3: r = 28'sd2086331;
			4: r = 28'sd1047214;
			5: r = 28'sd524117;
			6: r = 28'sd262123;
			7: r = 28'sd131069;
			8: r = 28'sd65536;
			9: r = 28'sd32768;
			10: r = 28'sd16384;
			11: r = 28'sd8192;
			12: r = 28'sd4096;
			13: r = 28'sd2048;
			14: r = 28'sd1024;
			15: r = 28'sd512;
			16: r = 28'sd256;
			17: r = 28'sd128;
			18: r = 28'sd64;
			19: r = 28'sd32;
			20: r = 28'sd16;
			21: r = 28'sd8;
			22: r = 28'sd4;
			23: r = 28'sd2;
			default: r = 28'sd0;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/ggws_if.sv
// Interfaces: pose word in, wheel speed word out
interface ggws_pose_if;
	logic valid;
	logic ready;
	logic position_valid;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] heading;
	modport source(output valid, position_valid, pos_x, pos_y, heading, input ready);
	modport sink(input valid, position_valid, pos_x, pos_y, heading, output ready);
endinterface

interface ggws_speed_if;
	logic valid;
	logic ready;
	logic signed [15:0] left_speed;
	logic signed [15:0] right_speed;
	modport source(output valid, left_speed, right_speed, input ready);
	modport sink(input valid, left_speed, right_speed, output ready);
endinterface

>>> hw/rtl/ggws_cordic.sv
// Pipelined CORDIC, one iteration per register stage, vectoring or rotation
module ggws_cordic #(
	parameter int STAGES = ggws_pkg::CORDIC_STAGES_DEF,
	parameter bit ROTATE = 1'b0,
	parameter int SW = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [ggws_pkg::XW-1:0] in_x,
	input  logic signed [ggws_pkg::XW-1:0] in_y,
	input  logic signed [ggws_pkg::ZW-1:0] in_z,
	input  logic [SW-1:0]                 in_side,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [ggws_pkg::XW-1:0] out_x,
	output logic signed [ggws_pkg::XW-1:0] out_y,
	output logic signed [ggws_pkg::ZW-1:0] out_z,
	output logic [SW-1:0]                 out_side
);
	localparam int XW = ggws_pkg::XW;
	localparam int ZW = ggws_pkg::ZW;

	logic v_s [STAGES];
	logic en [STAGES];
	logic signed [XW-1:0] x_s [STAGES];
	logic signed [XW-1:0] y_s [STAGES];
	logic signed [ZW-1:0] z_s [STAGES];
	logic [SW-1:0] side_s [STAGES];

	logic vn [STAGES];
	logic signed [XW-1:0] xn [STAGES];
	logic signed [XW-1:0] yn [STAGES];
	logic signed [ZW-1:0] zn [STAGES];
	logic [SW-1:0] sn [STAGES];

	// a stage may load when empty or when its word moves on
	always_comb begin
		en[STAGES-1] = ~v_s[STAGES-1] | out_ready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			en[k] = ~v_s[k] | en[k+1];
		end
	end

	assign in_ready = en[0];

	for (genvar i = 0; i < STAGES; i++) begin : g_st
		logic signed [XW-1:0] xi, yi;
		logic signed [ZW-1:0] zi;
		logic [SW-1:0] si;
		logic vi, up;
		if (i == 0) begin : g_first
			assign xi = in_x;
			assign yi = in_y;
			assign zi = in_z;
			assign si = in_side;
			assign vi = in_valid;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign si = side_s[i-1];
			assign vi = v_s[i-1];
		end
		// drive y to zero, or z to zero when rotating
		assign up = ROTATE ? ~zi[ZW-1] : yi[XW-1];
		assign xn[i] = up ? xi - (yi >>> i) : xi + (yi >>> i);
		assign yn[i] = up ? yi + (xi >>> i) : yi - (xi >>> i);
		assign zn[i] = up ? zi - ggws_pkg::atan_q24(i) : zi + ggws_pkg::atan_q24(i);
		assign sn[i] = si;
		assign vn[i] = vi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STAGES; k++) v_s[k] <= 1'b0;
		end else begin
			for (int k = 0; k < STAGES; k++) if (en[k]) v_s[k] <= vn[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < STAGES; k++) begin
			if (en[k]) begin
				x_s[k] <= xn[k];
				y_s[k] <= yn[k];
				z_s[k] <= zn[k];
				side_s[k] <= sn[k];
			end
		end
	end

	assign out_valid = v_s[STAGES-1];
	assign out_x = x_s[STAGES-1];
	assign out_y = y_s[STAGES-1];
	assign out_z = z_s[STAGES-1];
	assign out_side = side_s[STAGES-1];

endmodule

>>> hw/rtl/go_to_goal_wheel_speed.sv
// Top level: go-to-goal controller turning a pose into left and right wheel speeds
//
// Channels: pose (sink) carries one pose word per handshake: position_valid,
// pos_x, pos_y in mm and heading in Q3.12 radians. speed (source) carries
// left_speed and right_speed. A word is taken on a clock edge with valid and
// ready both high. A pose word with position_valid low is taken and dropped,
// so it gives no speed word.
// Configuration sits behind an APB-style port, one register each 4 bytes:
// goal_x, goal_y, gain_forward, gain_turn, half_axle, wheel_scale, speed limit.
// Write registers only while no pose is in flight.
// Throughput: one pose word per cycle while speed is not stalled. The pipe
// holds 2*CORDIC_STAGES + 11 register stages: the offset stage, the
// vectoring CORDIC (range and bearing), two stages for distance, error
// and angle reduction, the rotation CORDIC (cosine) and the eight multiply,
// sum, truncate and clamp stages behind it.
// Reset clears every stage valid bit and loads the register reset values.
// When the receiver stalls the output word holds and each stage keeps its
// word; empty stages behind it still fill, so pose is accepted until the
// pipe is full, then ready drops without losing or repeating a word.
module go_to_goal_wheel_speed #(
	parameter int CORDIC_STAGES = ggws_pkg::CORDIC_STAGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ggws_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	ggws_pose_if.sink                   pose,
	ggws_speed_if.source                speed
);
	localparam int XW = ggws_pkg::XW;
	localparam int ZW = ggws_pkg::ZW;
	localparam int DW = ggws_pkg::DW;
	localparam int EW = ggws_pkg::EW;
	localparam int VSW = 17;
	localparam int RSW = DW + EW + 1;

	// ---------------- configuration registers ----------------
	logic signed [15:0] goal_x_q, goal_y_q;
	logic [15:0] gain_forward_q, gain_turn_q, wheel_scale_q;
	logic [9:0] half_axle_q;
	logic [14:0] speed_lim_q;
	logic [25:0] hg_q;
	logic wr_en;
	ggws_pkg::reg_idx_t wr_idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign wr_idx = ggws_pkg::reg_idx_t'(paddr[ggws_pkg::ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q <= ggws_pkg::RST_GOAL_X;
			goal_y_q <= ggws_pkg::RST_GOAL_Y;
			gain_forward_q <= ggws_pkg::RST_GAIN_FORWARD;
			gain_turn_q <= ggws_pkg::RST_GAIN_TURN;
			half_axle_q <= ggws_pkg::RST_HALF_AXLE;
			wheel_scale_q <= ggws_pkg::RST_WHEEL_SCALE;
			speed_lim_q <= ggws_pkg::RST_SPEED_LIMIT;
		end else if (wr_en) begin
			case (wr_idx)
				ggws_pkg::REG_GOAL_X: goal_x_q <= $signed(pwdata[15:0]);
				ggws_pkg::REG_GOAL_Y: goal_y_q <= $signed(pwdata[15:0]);
				ggws_pkg::REG_GAIN_FORWARD: gain_forward_q <= pwdata[15:0];
				ggws_pkg::REG_GAIN_TURN: gain_turn_q <= pwdata[15:0];
				ggws_pkg::REG_HALF_AXLE: half_axle_q <= pwdata[9:0];
				ggws_pkg::REG_WHEEL_SCALE: wheel_scale_q <= pwdata[15:0];
				ggws_pkg::REG_SPEED_LIMIT: speed_lim_q <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	// half_axle * gain_turn folded ahead so the turn term needs one multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hg_q <= 26'(ggws_pkg::RST_HALF_AXLE) * 26'(ggws_pkg::RST_GAIN_TURN);
		end else begin
			hg_q <= 26'(half_axle_q) * 26'(gain_turn_q);
		end
	end

	always_comb begin
		case (wr_idx)
			ggws_pkg::REG_GOAL_X: prdata = 32'(goal_x_q);
			ggws_pkg::REG_GOAL_Y: prdata = 32'(goal_y_q);
			ggws_pkg::REG_GAIN_FORWARD: prdata = 32'(gain_forward_q);
			ggws_pkg::REG_GAIN_TURN: prdata = 32'(gain_turn_q);
			ggws_pkg::REG_HALF_AXLE: prdata = 32'(half_axle_q);
			ggws_pkg::REG_WHEEL_SCALE: prdata = 32'(wheel_scale_q);
			ggws_pkg::REG_SPEED_LIMIT: prdata = 32'(speed_lim_q);
			default: prdata = 32'd0;
		endcase
	end

	// ---------------- stage 1: goal offset and quarter-turn pre-rotation ----------------
	logic v_s1, en_s1;
	logic signed [XW-1:0] x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;
	logic [VSW-1:0] side_s1;
	logic signed [17:0] dx, dy;
	logic signed [XW-1:0] vx, vy, px, py;
	logic signed [ZW-1:0] pz;
	logic vec_in_ready;

	always_comb begin
		dx = 18'(goal_x_q) - 18'(pose.pos_x);
		dy = -18'(goal_y_q) - 18'(pose.pos_y);
		vx = XW'(dx) <<< 8;
		vy = XW'(dy) <<< 8;
		// bring the vector into the right half plane
		if (vx < 0) begin
			if (vy >= 0) begin
				px = vy;
				py = -vx;
				pz = ZW'(ggws_pkg::ANG_HALF_PI);
			end else begin
				px = -vy;
				py = vx;
				pz = -ZW'(ggws_pkg::ANG_HALF_PI);
			end
		end else begin
			px = vx;
			py = vy;
			pz = '0;
		end
	end

	assign en_s1 = ~v_s1 | vec_in_ready;
	assign pose.ready = en_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			x_s1 <= px;
			y_s1 <= py;
			z_s1 <= pz;
			// mark the exact-goal case: no angle, no range
			side_s1 <= {pose.heading, (dx == 18'sd0) && (dy == 18'sd0)};
		end
	end

	// ---------------- vectoring CORDIC: range and bearing ----------------
	logic vec_out_valid, vec_out_ready;
	logic signed [XW-1:0] vec_x, vec_y;
	logic signed [ZW-1:0] vec_z;
	logic [VSW-1:0] vec_side;

	ggws_cordic #(
		.STAGES(CORDIC_STAGES),
		.ROTATE(1'b0),
		.SW(VSW)
	) u_vec (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s1),
		.in_ready(vec_in_ready),
		.in_x(x_s1),
		.in_y(y_s1),
		.in_z(z_s1),
		.in_side(side_s1),
		.out_valid(vec_out_valid),
		.out_ready(vec_out_ready),
		.out_x(vec_x),
		.out_y(vec_y),
		.out_z(vec_z),
		.out_side(vec_side)
	);

	// ---------------- stage 2: distance and heading error ----------------
	logic v_s2, en_s2;
	logic signed [DW-1:0] dist_s2;
	logic signed [EW-1:0] err_s2;
	logic signed [XW-1:0] mag;
	logic signed [ZW-1:0] ang;
	logic signed [44:0] dprod;
	logic signed [15:0] hdg;

	always_comb begin
		mag = vec_side[0] ? '0 : vec_x;
		ang = vec_side[0] ? '0 : vec_z;
		hdg = $signed(vec_side[VSW-1:1]);
		dprod = 45'(mag) * 45'(ggws_pkg::INV_K_Q16);
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			dist_s2 <= $signed(dprod[DW+15:16]);
			err_s2 <= EW'(ang) - (EW'(hdg) <<< 12) - ggws_pkg::ANG_HALF_PI;
		end
	end

	// ---------------- stage 3: reduce the cosine angle into [-pi/2, pi/2] ----------------
	logic v_s3, en_s3;
	logic signed [DW-1:0] dist_s3;
	logic signed [EW-1:0] err_s3;
	logic signed [ZW-1:0] a_s3;
	logic neg_s3;
	logic signed [EW-1:0] ra;
	logic rneg;
	logic rot_in_ready;

	always_comb begin
		ra = err_s2;
		rneg = 1'b0;
		// two turns cover every reachable error; a third for margin
		for (int k = 0; k < 3; k++) begin
			if (ra > ggws_pkg::ANG_PI) ra = ra - ggws_pkg::ANG_TWO_PI;
			else if (ra < -ggws_pkg::ANG_PI) ra = ra + ggws_pkg::ANG_TWO_PI;
		end
		if (ra > ggws_pkg::ANG_HALF_PI) begin
			ra = ra - ggws_pkg::ANG_PI;
			rneg = 1'b1;
		end else if (ra < -ggws_pkg::ANG_HALF_PI) begin
			ra = ra + ggws_pkg::ANG_PI;
			rneg = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			dist_s3 <= dist_s2;
			err_s3 <= err_s2;
			a_s3 <= ZW'(ra);
			neg_s3 <= rneg;
		end
	end

	assign en_s3 = ~v_s3 | rot_in_ready;
	assign en_s2 = ~v_s2 | en_s3;
	assign vec_out_ready = en_s2;

	// ---------------- rotation CORDIC: cosine of the heading error ----------------
	logic rot_out_valid, rot_out_ready;
	logic signed [XW-1:0] rot_x, rot_y;
	logic signed [ZW-1:0] rot_z;
	logic [RSW-1:0] rot_side;

	ggws_cordic #(
		.STAGES(CORDIC_STAGES),
		.ROTATE(1'b1),
		.SW(RSW)
	) u_rot (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s3),
		.in_ready(rot_in_ready),
		.in_x(ggws_pkg::INV_K_Q24),
		.in_y('0),
		.in_z(a_s3),
		.in_side({dist_s3, err_s3, neg_s3}),
		.out_valid(rot_out_valid),
		.out_ready(rot_out_ready),
		.out_x(rot_x),
		.out_y(rot_y),
		.out_z(rot_z),
		.out_side(rot_side)
	);

	// ---------------- tail: products, sums, truncation and clamp ----------------
	logic v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic en_s4, en_s5, en_s6, en_s7, en_s8, en_s9, en_s10, en_s11;

	assign en_s11 = ~v_s11 | speed.ready;
	assign en_s10 = ~v_s10 | en_s11;
	assign en_s9 = ~v_s9 | en_s10;
	assign en_s8 = ~v_s8 | en_s9;
	assign en_s7 = ~v_s7 | en_s8;
	assign en_s6 = ~v_s6 | en_s7;
	assign en_s5 = ~v_s5 | en_s6;
	assign en_s4 = ~v_s4 | en_s5;
	assign rot_out_ready = en_s4;

	// stage 4: cosine sign, split dist*cos, turn product
	logic signed [XW-1:0] cosv;
	logic signed [DW-1:0] rdist;
	logic signed [EW-1:0] rerr;
	logic signed [41:0] phi_s4, plo_s4;
	logic signed [57:0] ax_s4;

	always_comb begin
		rdist = $signed(rot_side[RSW-1:EW+1]);
		rerr = $signed(rot_side[EW:1]);
		cosv = rot_side[0] ? -rot_x : rot_x;
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			phi_s4 <= 42'(rdist) * 42'(cosv >>> 13);
			plo_s4 <= 42'(rdist) * 42'($signed({1'b0, cosv[12:0]}));
			ax_s4 <= 58'($signed({1'b0, hg_q})) * 58'(rerr);
		end
	end

	// stage 5: join the partial products, floor by 2^24 and 2^16
	logic signed [51:0] fsum;
	logic signed [27:0] fp_s5;
	logic signed [41:0] axle_s5;

	assign fsum = (52'(phi_s4) <<< 13) + 52'(plo_s4);

	always_ff @(posedge clk) begin
		if (en_s5) begin
			fp_s5 <= $signed(fsum[51:24]);
			axle_s5 <= $signed(ax_s4[57:16]);
		end
	end

	// stage 6: forward gain
	logic signed [44:0] fwd_s6;
	logic signed [41:0] axle_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			fwd_s6 <= 45'(fp_s5) * 45'($signed({1'b0, gain_forward_q}));
			axle_s6 <= axle_s5;
		end
	end

	// stage 7: wheel sums
	logic signed [45:0] sl_s7, sr_s7;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			sl_s7 <= 46'(fwd_s6) - 46'(axle_s6);
			sr_s7 <= 46'(fwd_s6) + 46'(axle_s6);
		end
	end

	// stage 8: wheel scale, high and low halves apart
	logic signed [46:0] lh_s8, rh_s8;
	logic [32:0] ll_s8, rl_s8;
	logic signed [16:0] ws;

	assign ws = $signed({1'b0, wheel_scale_q});

	always_ff @(posedge clk) begin
		if (en_s8) begin
			lh_s8 <= 47'($signed(sl_s7[45:16])) * 47'(ws);
			rh_s8 <= 47'($signed(sr_s7[45:16])) * 47'(ws);
			ll_s8 <= 33'(sl_s7[15:0]) * 33'(wheel_scale_q);
			rl_s8 <= 33'(sr_s7[15:0]) * 33'(wheel_scale_q);
		end
	end

	// stage 9: full scaled products
	logic signed [63:0] lv_s9, rv_s9;

	always_ff @(posedge clk) begin
		if (en_s9) begin
			lv_s9 <= (64'(lh_s8) <<< 16) + $signed({31'd0, ll_s8});
			rv_s9 <= (64'(rh_s8) <<< 16) + $signed({31'd0, rl_s8});
		end
	end

	// stage 10: divide by 2^24 rounding toward zero
	logic signed [63:0] ladj, radj;
	logic signed [39:0] lt_s10, rt_s10;

	always_comb begin
		ladj = lv_s9 + $signed({40'd0, {24{lv_s9[63]}}});
		radj = rv_s9 + $signed({40'd0, {24{rv_s9[63]}}});
	end

	always_ff @(posedge clk) begin
		if (en_s10) begin
			lt_s10 <= $signed(ladj[63:24]);
			rt_s10 <= $signed(radj[63:24]);
		end
	end

	// stage 11: symmetric clamp, output register
	logic signed [39:0] lim;
	logic signed [15:0] lclamp, rclamp;
	logic signed [15:0] left_s11, right_s11;

	always_comb begin
		lim = 40'($signed({1'b0, speed_lim_q}));
		if (lt_s10 > lim) lclamp = 16'(lim);
		else if (lt_s10 < -lim) lclamp = 16'(-lim);
		else lclamp = 16'(lt_s10);
		if (rt_s10 > lim) rclamp = 16'(lim);
		else if (rt_s10 < -lim) rclamp = 16'(-lim);
		else rclamp = 16'(rt_s10);
	end

	always_ff @(posedge clk) begin
		if (en_s11) begin
			left_s11 <= lclamp;
			right_s11 <= rclamp;
		end
	end

	assign speed.valid = v_s11;
	assign speed.left_speed = left_s11;
	assign speed.right_speed = right_s11;

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			// drop poses without a calibrated fix here
			if (en_s1) v_s1 <= pose.valid & pose.position_valid;
			if (en_s2) v_s2 <= vec_out_valid;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= rot_out_valid;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
			if (en_s9) v_s9 <= v_s8;
			if (en_s10) v_s10 <= v_s9;
			if (en_s11) v_s11 <= v_s10;
		end
	end

endmodule

>>> hw/rtl/ggws_checker.sv
// Port checker for the go-to-goal wheel speed block, with its bind
`include "go_to_goal_wheel_speed_assert.svh"

module ggws_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               pose_ready,
	input logic               speed_valid,
	input logic               speed_ready,
	input logic signed [15:0] speed_left,
	input logic signed [15:0] speed_right
);

	// hold a stalled word
	`GGWS_ASSERT(a_out_hold, speed_valid && !speed_ready |=> speed_valid && $stable(speed_left) && $stable(speed_right), "speed word changed while stalled")

	// clamp is symmetric, so the most negative code never shows
	`GGWS_ASSERT(a_no_min, speed_valid |-> speed_left != 16'sh8000 && speed_right != 16'sh8000, "speed outside symmetric range")

	// an empty output stage means every stage can advance
	`GGWS_ASSERT(a_ready_free, !speed_valid |-> pose_ready, "pose stalled with output empty")

	// no word straight out of reset
	`GGWS_ASSERT_ALWAYS(a_rst_quiet, !$past(arst_n) |-> !speed_valid, "speed word right after reset")

endmodule

bind go_to_goal_wheel_speed ggws_checker u_ggws_checker (
	.clk(clk),
	.arst_n(arst_n),
	.pose_ready(pose.ready),
	.speed_valid(speed.valid),
	.speed_ready(speed.ready),
	.speed_left(speed.left_speed),
	.speed_right(speed.right_speed)
);

>>> bench/go_to_goal_wheel_speed_tb.sv
// Testbench for the go-to-goal wheel speed block: directed and random poses checked against a fixed-point predictor
module go_to_goal_wheel_speed_tb;

	localparam int STAGES = 16;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 2 * STAGES + 11 + 20;
	localparam int PHASE_ITEMS = 106;
	localparam int NUM_PHASES = 8;
	// an address past the last register, which the block must ignore
	localparam logic [ggws_pkg::ADDR_W-1:0] UNUSED_ADDR = 5'd28;

	// scoreboard: holds the wheel speed words that accepted poses should give
	class wheel_speed_board;
		longint goal_x, goal_y;
		longint gain_fwd, gain_rot, half_axle, wheel_scale, speed_lim;
		logic signed [15:0] left_q[$];
		logic signed [15:0] right_q[$];
		int fails;
		longint atan_lut[24];

		function new();
			atan_lut = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
				131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128,
				64, 32, 16, 8, 4, 2};
			fails = 0;
			goal_x = 0;
			goal_y = 0;
			gain_fwd = 256;
			gain_rot = 256;
			half_axle = 26;
			wheel_scale = 12490;
			speed_lim = 1000;
		endfunction

		function void set_reg(ggws_pkg::reg_idx_t idx, logic [31:0] val);
			case (idx)
				ggws_pkg::REG_GOAL_X: goal_x = longint'($signed(val[15:0]));
				ggws_pkg::REG_GOAL_Y: goal_y = longint'($signed(val[15:0]));
				ggws_pkg::REG_GAIN_FORWARD: gain_fwd = longint'(val[15:0]);
				ggws_pkg::REG_GAIN_TURN: gain_rot = longint'(val[15:0]);
				ggws_pkg::REG_HALF_AXLE: half_axle = longint'(val[9:0]);
				ggws_pkg::REG_WHEEL_SCALE: wheel_scale = longint'(val[15:0]);
				ggws_pkg::REG_SPEED_LIMIT: speed_lim = longint'(val[14:0]);
				default: ;
			endcase
		endfunction

		function longint trunc_q24(longint v);
			return (v < 0) ? -((-v) >>> 24) : (v >>> 24);
		endfunction

		function longint clamp(longint v);
			if (v > speed_lim)
				return speed_lim;
			if (v < -speed_lim)
				return -speed_lim;
			return v;
		endfunction

		function longint cosine(longint a);
			longint x, y, t;
			bit neg;
			x = 10188014;
			y = 0;
			neg = 0;
			while (a > 52707179)
				a -= 105414357;
			while (a < -52707179)
				a += 105414357;
			if (a > 26353589) begin
				a -= 52707179;
				neg = 1;
			end else if (a < -26353589) begin
				a += 52707179;
				neg = 1;
			end
			for (int i = 0; i < STAGES; i++) begin
				t = x;
				if (a >= 0) begin
					x -= y >>> i;
					y += t >>> i;
					a -= atan_lut[i];
				end else begin
					x += y >>> i;
					y -= t >>> i;
					a += atan_lut[i];
				end
			end
			return neg ? -x : x;
		endfunction

		// work out the wheel speeds for one valid pose
		function void note_pose(logic pv, logic signed [15:0] px, logic signed [15:0] py,
				logic signed [15:0] hd);
			longint x, y, z, t, range_mm, err, fwd, axle, lft, rgt;
			if (!pv)
				return;
			x = (goal_x - longint'(px)) * 256;
			y = (-goal_y - longint'(py)) * 256;
			z = 0;
			if (x == 0 && y == 0) begin
				x = 0;
			end else begin
				if (x < 0) begin
					t = x;
					if (y >= 0) begin
						x = y;
						y = -t;
						z = 26353589;
					end else begin
						x = -y;
						y = t;
						z = -26353589;
					end
				end
				for (int i = 0; i < STAGES; i++) begin
					t = x;
					if (y >= 0) begin
						x += y >>> i;
						y -= t >>> i;
						z += atan_lut[i];
					end else begin
						x -= y >>> i;
						y += t >>> i;
						z -= atan_lut[i];
					end
				end
			end
			range_mm = (x * 39797) >>> 16;
			err = z - longint'(hd) * 4096 - 26353589;
			fwd = ((range_mm * cosine(err)) >>> 24) * gain_fwd;
			axle = (half_axle * (gain_rot * err)) >>> 16;
			lft = clamp(trunc_q24((fwd - axle) * wheel_scale));
			rgt = clamp(trunc_q24((fwd + axle) * wheel_scale));
			left_q.push_back(lft[15:0]);
			right_q.push_back(rgt[15:0]);
		endfunction

		function void check_speed(logic signed [15:0] l, logic signed [15:0] r);
			logic signed [15:0] el, er;
			if (left_q.size() == 0) begin
				$error("unexpected speed word left_speed=%0d right_speed=%0d", l, r);
				fails++;
				return;
			end
			el = left_q.pop_front();
			er = right_q.pop_front();
			if (l !== el) begin
				$error("left_speed expected %0d actual %0d", el, l);
				fails++;
			end
			if (r !== er) begin
				$error("right_speed expected %0d actual %0d", er, r);
				fails++;
			end
		endfunction

		function int pending();
			return left_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ggws_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	ggws_pose_if pose_ch();
	ggws_speed_if speed_ch();

	wheel_speed_board board;
	int idle_pct;
	int stall_pct;
	bit long_hold_req;
	bit long_hold_done;
	int hold_left;
	int cycles;

	go_to_goal_wheel_speed #(.CORDIC_STAGES(STAGES)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.pose(pose_ch),
		.speed(speed_ch)
	);

	always #6 clk = ~clk;

	// watchdog: end the run as failed once it runs past LIMIT_CYCLES
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: stall at random, and hold off for one long stretch when asked
	always @(posedge clk) begin
		if (long_hold_req && !long_hold_done) begin
			long_hold_done = 1;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			speed_ch.ready <= 1'b0;
		end else begin
			speed_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// check each speed word taken on this edge
	always @(posedge clk) begin
		if (arst_n && speed_ch.valid && speed_ch.ready)
			board.check_speed(speed_ch.left_speed, speed_ch.right_speed);
	end

	// APB write: setup cycle, access cycle, then release the bus
	task automatic apb_write(logic [ggws_pkg::ADDR_W-1:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_reg(ggws_pkg::reg_idx_t idx, logic [31:0] data);
		apb_write(ggws_pkg::ADDR_W'(4 * int'(idx)), data);
		board.set_reg(idx, data);
	endtask

	// offer one pose word, hold it until taken, then maybe idle a while
	task automatic send_pose(logic pv, logic signed [15:0] px, logic signed [15:0] py,
			logic signed [15:0] hd);
		pose_ch.valid <= 1'b1;
		pose_ch.position_valid <= pv;
		pose_ch.pos_x <= px;
		pose_ch.pos_y <= py;
		pose_ch.heading <= hd;
		@(posedge clk);
		while (!pose_ch.ready)
			@(posedge clk);
		board.note_pose(pv, px, py, hd);
		if ($urandom_range(99) < idle_pct) begin
			pose_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// wait until every expected word has come, then let the pipe empty
	task automatic drain();
		pose_ch.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_pose();
		logic pv;
		logic signed [15:0] px, py, hd;
		pv = ($urandom_range(99) < 88);
		case ($urandom_range(3))
			0: begin
				// close to the goal
				px = 16'(board.goal_x + $signed($urandom_range(0, 64)) - 32);
				py = 16'(-board.goal_y + $signed($urandom_range(0, 64)) - 32);
			end
			default: begin
				px = 16'($urandom);
				py = 16'($urandom);
			end
		endcase
		if ($urandom_range(9) == 0)
			hd = 16'($urandom);
		else
			hd = 16'($signed($urandom_range(0, 51472)) - 25736);
		send_pose(pv, px, py, hd);
	endtask

	task automatic config_phase(int ph);
		case (ph)
			0: begin
				write_reg(ggws_pkg::REG_GOAL_X, 32'd0);
				write_reg(ggws_pkg::REG_GOAL_Y, 32'd0);
				write_reg(ggws_pkg::REG_GAIN_FORWARD, 32'd256);
				write_reg(ggws_pkg::REG_GAIN_TURN, 32'd256);
				write_reg(ggws_pkg::REG_HALF_AXLE, 32'd26);
				write_reg(ggws_pkg::REG_WHEEL_SCALE, 32'd12490);
				write_reg(ggws_pkg::REG_SPEED_LIMIT, 32'd1000);
			end
			1: begin
				// top of every range, with goal_y at its most negative
				write_reg(ggws_pkg::REG_GOAL_X, 32'h7FFF);
				write_reg(ggws_pkg::REG_GOAL_Y, 32'h8000);
				write_reg(ggws_pkg::REG_GAIN_FORWARD, 32'hFFFF);
				write_reg(ggws_pkg::REG_GAIN_TURN, 32'hFFFF);
				write_reg(ggws_pkg::REG_HALF_AXLE, 32'h3FF);
				write_reg(ggws_pkg::REG_WHEEL_SCALE, 32'hFFFF);
				write_reg(ggws_pkg::REG_SPEED_LIMIT, 32'h7FFF);
			end
			2: begin
				// zero limit and zero gains
				write_reg(ggws_pkg::REG_GOAL_X, 32'h8000);
				write_reg(ggws_pkg::REG_GOAL_Y, 32'h7FFF);
				write_reg(ggws_pkg::REG_GAIN_FORWARD, 32'd0);
				write_reg(ggws_pkg::REG_GAIN_TURN, 32'd0);
				write_reg(ggws_pkg::REG_HALF_AXLE, 32'd0);
				write_reg(ggws_pkg::REG_WHEEL_SCALE, 32'd0);
				write_reg(ggws_pkg::REG_SPEED_LIMIT, 32'd0);
			end
			default: begin
				write_reg(ggws_pkg::REG_GOAL_X, $urandom);
				write_reg(ggws_pkg::REG_GOAL_Y, $urandom);
				write_reg(ggws_pkg::REG_GAIN_FORWARD, $urandom_range(0, 2048));
				write_reg(ggws_pkg::REG_GAIN_TURN, $urandom_range(0, 2048));
				write_reg(ggws_pkg::REG_HALF_AXLE, $urandom);
				write_reg(ggws_pkg::REG_WHEEL_SCALE, $urandom);
				write_reg(ggws_pkg::REG_SPEED_LIMIT, $urandom_range(1, 32767));
				// an address past the map must change nothing
				apb_write(UNUSED_ADDR, $urandom);
			end
		endcase
	endtask

	initial begin
		board = new();
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pose_ch.valid = 1'b0;
		pose_ch.position_valid = 1'b0;
		pose_ch.pos_x = '0;
		pose_ch.pos_y = '0;
		pose_ch.heading = '0;
		speed_ch.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		long_hold_req = 0;
		long_hold_done = 0;
		hold_left = 0;
		cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed poses at reset settings: goal reached, invalid, extremes
		send_pose(1'b1, 16'sd0, 16'sd0, 16'sd0);
		send_pose(1'b0, 16'sd100, 16'sd100, 16'sd0);
		send_pose(1'b1, 16'sd0, 16'sd0, 16'sd25736);
		send_pose(1'b1, -16'sd32768, -16'sd32768, -16'sd25736);
		send_pose(1'b1, 16'sd32767, 16'sd32767, 16'sd25736);
		send_pose(1'b1, -16'sd32768, 16'sd32767, -16'sd32768);
		send_pose(1'b1, 16'sd32767, -16'sd32768, 16'sd32767);
		send_pose(1'b1, 16'sd1000, 16'sd0, 16'sd0);
		send_pose(1'b1, -16'sd1000, 16'sd0, 16'sd0);
		send_pose(1'b1, 16'sd0, 16'sd1000, 16'sd6434);
		send_pose(1'b1, 16'sd0, -16'sd1000, -16'sd6434);
		send_pose(1'b1, -16'sd1, -16'sd1, 16'sd12868);
		send_pose(1'b1, 16'sd1, 16'sd1, -16'sd12868);
		send_pose(1'b0, -16'sd32768, 16'sd32767, -16'sd1);
		send_pose(1'b1, 16'sd50, -16'sd20, -16'sd1);
		drain();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			config_phase(ph);
			// idling pattern: none, sender, receiver, both lightly
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 61; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 61; end
				default: begin idle_pct = 7; stall_pct = 7; end
			endcase
			// hold the receiver off for a long stretch so the pipe fills
			if (ph == 4)
				long_hold_req = 1;
			if (ph == 1) begin
				// one millimetre short of the goal at the far corner
				send_pose(1'b1, 16'sd32767, 16'sd32767, 16'sd0);
			end
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_pose();
			drain();
		end

		if (board.fails == 0 && board.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/ggws_pkg.sv
hw/rtl/ggws_if.sv
hw/rtl/ggws_cordic.sv
hw/rtl/go_to_goal_wheel_speed.sv
hw/rtl/ggws_checker.sv
bench/go_to_goal_wheel_speed_tb.sv
